### hw/rtl/amx_pkg.sv
package amx_pkg;

    // Word format of every matrix entry and operand
    localparam int WORD_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_ENTRIES   = 6;

    localparam int KIND_W = 3;
    localparam int TURN_W = 2;

    // Operation codes carried by a request
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD     = 3'd0,
        KIND_MUL      = 3'd1,
        KIND_TRANS    = 3'd2,
        KIND_SCALE    = 3'd3,
        KIND_ROT      = 3'd4,
        KIND_ROT_MOVE = 3'd5
    } kind_t;

    // Quarter-turn codes, counterclockwise
    typedef enum logic [TURN_W-1:0] {
        TURN_0   = 2'd0,
        TURN_90  = 2'd1,
        TURN_180 = 2'd2,
        TURN_270 = 2'd3
    } turn_t;

    typedef logic signed [WORD_W-1:0] word_t;

endpackage

### hw/rtl/amx_dot2.sv
// Two-term fixed-point dot product: round((x1*y1 + x2*y2) / 2^FRAC_BITS) + add,
// rounded to nearest with ties up, saturated to one word.
module amx_dot2 #(
    parameter int FRAC_BITS = amx_pkg::FRAC_BITS_DEF
) (
    input  amx_pkg::word_t x1,
    input  amx_pkg::word_t y1,
    input  amx_pkg::word_t x2,
    input  amx_pkg::word_t y2,
    input  amx_pkg::word_t add,
    output amx_pkg::word_t res,
    output logic           sat
);

    localparam int PROD_W = 2 * amx_pkg::WORD_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int TOT_W  = SUM_W + 1;
    localparam int HI_W   = TOT_W - amx_pkg::WORD_W + 1;

    localparam logic signed [SUM_W-1:0] HALF =
        {{(SUM_W-1){1'b0}}, 1'b1} <<< (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod1;
    logic signed [PROD_W-1:0] prod2;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  shifted;
    logic signed [TOT_W-1:0]  total;
    logic        [HI_W-1:0]   hi_bits;

    // Exact products and their sum with the rounding half
    assign prod1 = PROD_W'(x1) * PROD_W'(y1);
    assign prod2 = PROD_W'(x2) * PROD_W'(y2);
    assign sum   = SUM_W'(prod1) + SUM_W'(prod2) + HALF;

    // Drop fraction bits (floor), then add the offset
    assign shifted = sum >>> FRAC_BITS;
    assign total   = TOT_W'(shifted) + TOT_W'(add);

    // Saturate when the top bits are not a pure sign extension
    assign hi_bits = total[TOT_W-1:amx_pkg::WORD_W-1];

    always_comb
    begin
        sat = !((&hi_bits) || !(|hi_bits));
        if (!sat)
        begin
            res = total[amx_pkg::WORD_W-1:0];
        end
        else if (total[TOT_W-1])
        begin
            res = {1'b1, {(amx_pkg::WORD_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(amx_pkg::WORD_W-1){1'b1}}};
        end
    end

endmodule

### hw/rtl/affine_matrix_accumulator_core.sv
// Affine matrix accumulator: one request per cycle while no held result stalls it.
// A request is held in the input stage; its result is registered when the
// output is free; each request is worked in a single pass of one multiplier layer.
// Throughput: one request per cycle; the only stall comes from a held result.
// Reset (rst_n low, asynchronous): matrix returns to identity, no result pending.
module affine_matrix_accumulator_core #(
    parameter int FRAC_BITS = amx_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [amx_pkg::KIND_W-1:0] kind,
    input  amx_pkg::word_t             coef_a,
    input  amx_pkg::word_t             coef_b,
    input  amx_pkg::word_t             coef_c,
    input  amx_pkg::word_t             coef_d,
    input  amx_pkg::word_t             coef_e,
    input  amx_pkg::word_t             coef_f,
    input  logic [amx_pkg::TURN_W-1:0] quarter_turns,
    input  amx_pkg::word_t             x_operand,
    input  amx_pkg::word_t             y_operand,

    output logic                       res_valid,
    input  logic                       res_stall,
    output amx_pkg::word_t             out_a,
    output amx_pkg::word_t             out_b,
    output amx_pkg::word_t             out_c,
    output amx_pkg::word_t             out_d,
    output amx_pkg::word_t             out_e,
    output amx_pkg::word_t             out_f,
    output logic                       overflow
);

    localparam int W = amx_pkg::WORD_W;
    localparam int N = amx_pkg::NUM_ENTRIES;

    localparam amx_pkg::word_t ONE  = W'(1) << FRAC_BITS;
    localparam amx_pkg::word_t ZERO = '0;
    localparam amx_pkg::word_t MINV = {1'b1, {(W-1){1'b0}}};
    localparam amx_pkg::word_t MAXV = {1'b0, {(W-1){1'b1}}};

    // Saturating negate: returns {saturated, value}
    function automatic logic [W:0] neg_sat(input amx_pkg::word_t v);
        logic [W:0] r;
        if (v == MINV)
        begin
            r = {1'b1, MAXV};
        end
        else
        begin
            r = {1'b0, -v};
        end
        return r;
    endfunction

    // Input stage
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [amx_pkg::KIND_W-1:0] kind_reg;
    logic [amx_pkg::TURN_W-1:0] turn_reg;
    amx_pkg::word_t             coef_reg [N];
    amx_pkg::word_t             xo_reg;
    amx_pkg::word_t             yo_reg;

    // State and result stage
    amx_pkg::word_t             mtx_reg  [N];
    amx_pkg::word_t             mtx_next [N];
    logic                       res_valid_reg;
    logic                       res_valid_next;
    amx_pkg::word_t             res_reg  [N];
    logic                       ovf_reg;
    logic                       ovf_next;

    logic                       req_acc;
    logic                       advance;

    // Handshake: hold the input stage only while a finished result is held
    assign advance   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall = s1_valid_reg && res_valid_reg && res_stall;
    assign req_acc   = req_valid && !req_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg && res_stall;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
    end

    // Request payload capture
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            kind_reg    <= kind;
            turn_reg    <= quarter_turns;
            coef_reg[0] <= coef_a;
            coef_reg[1] <= coef_b;
            coef_reg[2] <= coef_c;
            coef_reg[3] <= coef_d;
            coef_reg[4] <= coef_e;
            coef_reg[5] <= coef_f;
            xo_reg      <= x_operand;
            yo_reg      <= y_operand;
        end
    end

    // Quarter-turn rotation of the linear part
    amx_pkg::word_t rot_m [4];
    logic           rot_sat;
    logic [W:0]     neg_a;
    logic [W:0]     neg_b;
    logic [W:0]     neg_c;
    logic [W:0]     neg_d;

    assign neg_a = neg_sat(mtx_reg[0]);
    assign neg_b = neg_sat(mtx_reg[1]);
    assign neg_c = neg_sat(mtx_reg[2]);
    assign neg_d = neg_sat(mtx_reg[3]);

    always_comb
    begin
        rot_m[0] = mtx_reg[0];
        rot_m[1] = mtx_reg[1];
        rot_m[2] = mtx_reg[2];
        rot_m[3] = mtx_reg[3];
        rot_sat  = 1'b0;
        case (turn_reg)
            amx_pkg::TURN_90:
            begin
                rot_m[0] = mtx_reg[2];
                rot_m[1] = mtx_reg[3];
                rot_m[2] = neg_a[W-1:0];
                rot_m[3] = neg_b[W-1:0];
                rot_sat  = neg_a[W] | neg_b[W];
            end
            amx_pkg::TURN_180:
            begin
                rot_m[0] = neg_a[W-1:0];
                rot_m[1] = neg_b[W-1:0];
                rot_m[2] = neg_c[W-1:0];
                rot_m[3] = neg_d[W-1:0];
                rot_sat  = neg_a[W] | neg_b[W] | neg_c[W] | neg_d[W];
            end
            amx_pkg::TURN_270:
            begin
                rot_m[0] = neg_c[W-1:0];
                rot_m[1] = neg_d[W-1:0];
                rot_m[2] = mtx_reg[0];
                rot_m[3] = mtx_reg[1];
                rot_sat  = neg_c[W] | neg_d[W];
            end
            default:
            begin
                rot_sat = 1'b0;
            end
        endcase
    end

    // Operand selection for the six dot products
    logic           is_rot;
    amx_pkg::word_t lin_m [4];
    amx_pkg::word_t m0x;
    amx_pkg::word_t m0y;
    amx_pkg::word_t m2x;
    amx_pkg::word_t m2y;
    amx_pkg::word_t tx;
    amx_pkg::word_t ty;

    assign is_rot = (kind_reg == amx_pkg::KIND_ROT) || (kind_reg == amx_pkg::KIND_ROT_MOVE);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lin_m[i] = is_rot ? rot_m[i] : mtx_reg[i];
        end
    end

    always_comb
    begin
        m0x = ZERO;
        m0y = ZERO;
        m2x = ZERO;
        m2y = ZERO;
        tx  = ZERO;
        ty  = ZERO;
        case (kind_reg)
            amx_pkg::KIND_MUL:
            begin
                m0x = coef_reg[0];
                m0y = coef_reg[1];
                m2x = coef_reg[2];
                m2y = coef_reg[3];
                tx  = coef_reg[4];
                ty  = coef_reg[5];
            end
            amx_pkg::KIND_TRANS:
            begin
                tx = xo_reg;
                ty = yo_reg;
            end
            amx_pkg::KIND_SCALE:
            begin
                m0x = xo_reg;
                m2y = yo_reg;
            end
            amx_pkg::KIND_ROT_MOVE:
            begin
                // Shift back onto the page after the turn
                if (turn_reg == amx_pkg::TURN_90 || turn_reg == amx_pkg::TURN_180)
                begin
                    tx = xo_reg;
                end
                if (turn_reg == amx_pkg::TURN_180 || turn_reg == amx_pkg::TURN_270)
                begin
                    ty = yo_reg;
                end
            end
            default:
            begin
                tx = ZERO;
            end
        endcase
    end

    // Dot-product units, one per matrix entry
    amx_pkg::word_t dx1 [N];
    amx_pkg::word_t dy1 [N];
    amx_pkg::word_t dx2 [N];
    amx_pkg::word_t dy2 [N];
    amx_pkg::word_t dadd[N];
    amx_pkg::word_t dres[N];
    logic [N-1:0]   dsat;

    always_comb
    begin
        dx1[0] = mtx_reg[0]; dy1[0] = m0x; dx2[0] = mtx_reg[2]; dy2[0] = m0y; dadd[0] = ZERO;
        dx1[1] = mtx_reg[1]; dy1[1] = m0x; dx2[1] = mtx_reg[3]; dy2[1] = m0y; dadd[1] = ZERO;
        dx1[2] = mtx_reg[0]; dy1[2] = m2x; dx2[2] = mtx_reg[2]; dy2[2] = m2y; dadd[2] = ZERO;
        dx1[3] = mtx_reg[1]; dy1[3] = m2x; dx2[3] = mtx_reg[3]; dy2[3] = m2y; dadd[3] = ZERO;
        dx1[4] = lin_m[0];   dy1[4] = tx;  dx2[4] = lin_m[2];   dy2[4] = ty;  dadd[4] = mtx_reg[4];
        dx1[5] = lin_m[1];   dy1[5] = tx;  dx2[5] = lin_m[3];   dy2[5] = ty;  dadd[5] = mtx_reg[5];
    end

    for (genvar g = 0; g < N; g++)
    begin : g_dot
        amx_dot2 #(
            .FRAC_BITS (FRAC_BITS)
        ) u_dot (
            .x1  (dx1[g]),
            .y1  (dy1[g]),
            .x2  (dx2[g]),
            .y2  (dy2[g]),
            .add (dadd[g]),
            .res (dres[g]),
            .sat (dsat[g])
        );
    end

    // Next matrix and overflow per operation
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            mtx_next[i] = mtx_reg[i];
        end
        ovf_next = 1'b0;
        case (kind_reg)
            amx_pkg::KIND_LOAD:
            begin
                for (int i = 0; i < N; i++)
                begin
                    mtx_next[i] = coef_reg[i];
                end
            end
            amx_pkg::KIND_MUL:
            begin
                for (int i = 0; i < N; i++)
                begin
                    mtx_next[i] = dres[i];
                end
                ovf_next = |dsat;
            end
            amx_pkg::KIND_TRANS:
            begin
                mtx_next[4] = dres[4];
                mtx_next[5] = dres[5];
                ovf_next    = dsat[4] | dsat[5];
            end
            amx_pkg::KIND_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mtx_next[i] = dres[i];
                end
                ovf_next = |dsat[3:0];
            end
            amx_pkg::KIND_ROT, amx_pkg::KIND_ROT_MOVE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mtx_next[i] = rot_m[i];
                end
                mtx_next[4] = dres[4];
                mtx_next[5] = dres[5];
                ovf_next    = rot_sat | dsat[4] | dsat[5];
            end
            default:
            begin
                ovf_next = 1'b0;
            end
        endcase
    end

    // Control state and matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            mtx_reg[0]    <= ONE;
            mtx_reg[1]    <= ZERO;
            mtx_reg[2]    <= ZERO;
            mtx_reg[3]    <= ONE;
            mtx_reg[4]    <= ZERO;
            mtx_reg[5]    <= ZERO;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                for (int i = 0; i < N; i++)
                begin
                    mtx_reg[i] <= mtx_next[i];
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < N; i++)
            begin
                res_reg[i] <= mtx_next[i];
            end
            ovf_reg <= ovf_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign out_a     = res_reg[0];
    assign out_b     = res_reg[1];
    assign out_c     = res_reg[2];
    assign out_d     = res_reg[3];
    assign out_e     = res_reg[4];
    assign out_f     = res_reg[5];
    assign overflow  = ovf_reg;

endmodule

### hw/rtl/amx_checker.sv
// Port-level checks for the affine matrix accumulator
module amx_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_stall,
    input logic [amx_pkg::KIND_W-1:0] kind,
    input amx_pkg::word_t             coef_a,
    input amx_pkg::word_t             coef_f,
    input logic                       res_valid,
    input logic                       res_stall,
    input amx_pkg::word_t             out_a,
    input amx_pkg::word_t             out_f,
    input logic                       overflow
);

    // Requests back up only behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (res_valid && res_stall))
    else $error("request stalled while result path is free");

    // Held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(out_a) && $stable(overflow)))
    else $error("held result changed");

    // A load comes back unchanged through the input and result stages when the output is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && kind == amx_pkg::KIND_LOAD) ##1 !res_stall
        |=> (res_valid && out_a == $past(coef_a, 2) && out_f == $past(coef_f, 2)
             && !overflow))
    else $error("load result mismatch");

    // Unused operation codes never report overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && kind > amx_pkg::KIND_ROT_MOVE) ##1 !res_stall
        |=> (res_valid && !overflow))
    else $error("overflow on unused operation");

endmodule

bind affine_matrix_accumulator_core amx_checker u_amx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .kind      (kind),
    .coef_a    (coef_a),
    .coef_f    (coef_f),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_a     (out_a),
    .out_f     (out_f),
    .overflow  (overflow)
);
